// File: src/hierarchical_sample_warp_defines.svh
// Assertion macros shared by the hierarchical sample warp RTL.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef HIERARCHICAL_SAMPLE_WARP_DEFINES_SVH
`define HIERARCHICAL_SAMPLE_WARP_DEFINES_SVH

// Same-cycle implication.
`define HSW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hierarchical_sample_warp: same-cycle check failed");

// Next-cycle implication.
`define HSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hierarchical_sample_warp: next-cycle check failed");

`endif

// File: src/hsw_pkg.sv
// Types and constants for the hierarchical sample warp.
// No dependencies; used by hsw_div and hierarchical_sample_warp.
package hsw_pkg;

    localparam int MODE_W    = 2;
    localparam int LEVEL_W   = 3;
    localparam int ROWCOL_W  = 6;
    localparam int WEIGHT_W  = 32;
    localparam int COORD_W   = 16;
    localparam int DENSITY_W = 44;
    localparam int CFG_W     = 3;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;
    localparam int SUM_W     = WEIGHT_W + 1;
    localparam int TOT_W     = WEIGHT_W + 2;

    // Input word layout, lowest bit first.
    localparam int LEVEL_LSB  = 0;
    localparam int ROW_LSB    = LEVEL_LSB + LEVEL_W;
    localparam int COL_LSB    = ROW_LSB + ROWCOL_W;
    localparam int WEIGHT_LSB = COL_LSB + ROWCOL_W;
    localparam int U_LSB      = WEIGHT_LSB + WEIGHT_W;
    localparam int V_LSB      = U_LSB + COORD_W;
    localparam int S_USED_W   = V_LSB + COORD_W;

    localparam int M_USED_W = 2 * COORD_W + DENSITY_W;

    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WARP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DENSITY = 2'd2;

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_RD_ISSUE   = 9'b000000010,
        S_RD_CAPTURE = 9'b000000100,
        S_MUL        = 9'b000001000,
        S_CMP        = 9'b000010000,
        S_DIV        = 9'b000100000,
        S_FINISH     = 9'b001000000,
        S_DENS_RD    = 9'b010000000,
        S_DENS_CAP   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: src/hierarchical_sample_warp.sv
// Top level of the hierarchical sample warp: weight pyramid store and warp sequencer.
// Depends on hsw_pkg, hsw_div and hierarchical_sample_warp_defines.svh.
//
// Usage: words arrive on the s_axis channel; tuser carries the mode (write weight,
// warp a sample, evaluate density) and tdata the level, row, col, weight, u and v.
// Each accepted word yields exactly one result word on m_axis: warped x_out and
// y_out, or the density, with unused fields zero. A weight write stores one entry
// of the pyramid and answers with an all-zero word.
// The levels_used register is written through cfg_we / cfg_wdata while idle; the
// user must keep to this, the block itself does not enforce it. A write or an
// unknown mode sets the result register when it is accepted; a density query
// passes through address, memory read, and scale and saturate. A warp, per level,
// reads the four cells of the 2x2 block from the weight memory and then runs two
// splits on the shared multiplier and restoring divider.
// One word is in flight at a time: s_axis_tready is high only when the sequencer
// is idle and the result register is empty, so a stalled receiver holds the
// result and back-pressures the input. Reset clears control state and sets
// levels_used to 6; the weight memory is not cleared and must be written before
// it is read.
module hierarchical_sample_warp
    import hsw_pkg::*;
#(
    parameter int MAX_LEVELS = 6,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,      // levels_used
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // level, row, col, weight, u, v, zero pad
    input  logic [MODE_W-1:0]    s_axis_tuser,   // mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // x_out, y_out, density, zero pad
);

`include "hierarchical_sample_warp_defines.svh"

    localparam int STORE_DEPTH = ((1 << (2 * MAX_LEVELS + 2)) - 4) / 3;
    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int LW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int NW   = $clog2(MAX_LEVELS + 1);
    localparam int ML   = MAX_LEVELS;
    localparam int F    = FRAC_BITS;
    localparam int DVD_W = F + TOT_W;
    localparam int PW   = ML + F;

    // Level base addresses, levels packed coarsest first.
    logic [AW-1:0] base_tbl [MAX_LEVELS];
    for (genvar g = 0; g < MAX_LEVELS; g++)
    begin : g_base
        assign base_tbl[g] = AW'(((64'd1 << (2 * g + 2)) - 64'd4) / 64'd3);
    end

    logic [WEIGHT_W-1:0] mem [STORE_DEPTH];
    logic [WEIGHT_W-1:0] mem_rd_reg;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    levels_used_reg;
    logic [NW-1:0]       n_eff;
    logic [NW-1:0]       n_reg;
    logic [LW-1:0]       lvl_reg;
    logic [1:0]          k_reg;
    logic [ML-1:0]       r_reg, c_reg;
    logic [F-1:0]        x_reg, y_reg;
    logic [WEIGHT_W-1:0] cell_reg [4];
    logic                phase_reg;
    logic                down_reg;
    logic [SUM_W-1:0]    sa_reg, sb_reg;
    logic [DVD_W-1:0]    lhs_reg;
    logic                part_reg;
    logic                keep_reg;

    logic                out_valid_reg;
    logic [COORD_W-1:0]  out_x_reg, out_y_reg;
    logic [DENSITY_W-1:0] out_d_reg;

    logic                accept;
    logic [MODE_W-1:0]   in_mode;
    logic [LEVEL_W-1:0]  in_level;
    logic [ROWCOL_W-1:0] in_row, in_col;
    logic [WEIGHT_W-1:0] in_weight;
    logic [COORD_W-1:0]  in_u, in_v;

    logic [TOT_W-1:0]    tot;
    logic [DVD_W-1:0]    rhs;
    logic                lhs_lt;
    logic [SUM_W-1:0]    divisor;
    logic [DVD_W-1:0]    dividend;
    logic                div_start;
    logic [F-1:0]        quotient;
    div_status_t         div_stat;
    logic [F-1:0]        coord;

    logic [ML-1:0]       rd_row, rd_col;
    logic [ML-1:0]       dens_row, dens_col;
    logic [LW-1:0]       dens_lvl;
    logic [PW-1:0]       px_tmp, py_tmp;
    logic [63:0]         dens_wide;

    assign in_mode   = s_axis_tuser;
    assign in_level  = s_axis_tdata[LEVEL_LSB +: LEVEL_W];
    assign in_row    = s_axis_tdata[ROW_LSB +: ROWCOL_W];
    assign in_col    = s_axis_tdata[COL_LSB +: ROWCOL_W];
    assign in_weight = s_axis_tdata[WEIGHT_LSB +: WEIGHT_W];
    assign in_u      = s_axis_tdata[U_LSB +: COORD_W];
    assign in_v      = s_axis_tdata[V_LSB +: COORD_W];

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Clamp the configured level count into 1 .. MAX_LEVELS.
    always_comb
    begin
        if (levels_used_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(levels_used_reg) > MAX_LEVELS)
        begin
            n_eff = NW'(MAX_LEVELS);
        end
        else
        begin
            n_eff = NW'(levels_used_reg);
        end
    end

    // Weight writes go straight from the input word; out-of-range cells are dropped.
    assign wr_en = accept && (in_mode == MODE_WRITE) && (int'(in_level) < MAX_LEVELS)
                   && ((in_row >> (in_level + 1'b1)) == '0)
                   && ((in_col >> (in_level + 1'b1)) == '0);
    assign wr_addr = base_tbl[LW'(in_level)] + (AW'(in_row) << (in_level + 1'b1))
                     + AW'(in_col);

    // Read address: one cell of the 2x2 block for a warp, or the density cell.
    assign rd_row   = r_reg + ML'(k_reg[1]);
    assign rd_col   = c_reg + ML'(k_reg[0]);
    assign py_tmp   = (PW'(y_reg) << n_reg) >> F;
    assign px_tmp   = (PW'(x_reg) << n_reg) >> F;
    assign dens_row = ML'(py_tmp);
    assign dens_col = ML'(px_tmp);
    assign dens_lvl = LW'(n_reg - 1'b1);

    always_comb
    begin
        if (state_reg == S_DENS_RD)
        begin
            rd_addr = base_tbl[dens_lvl] + (AW'(dens_row) << (dens_lvl + 1'b1))
                      + AW'(dens_col);
        end
        else
        begin
            rd_addr = base_tbl[lvl_reg] + (AW'(rd_row) << (lvl_reg + 1'b1)) + AW'(rd_col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_weight;
        end
        mem_rd_reg <= mem[rd_addr];
    end

    // Split arithmetic: pick a part by coord * (a + b) < a << F, then rescale.
    assign coord    = phase_reg ? x_reg : y_reg;
    assign tot      = TOT_W'(sa_reg) + TOT_W'(sb_reg);
    assign rhs      = DVD_W'(sa_reg) << F;
    assign lhs_lt   = (lhs_reg < rhs);
    assign divisor  = lhs_lt ? sa_reg : sb_reg;
    assign dividend = lhs_lt ? lhs_reg : (lhs_reg - rhs);
    assign div_start = (state_reg == S_CMP) && (divisor != '0);

    hsw_div #(
        .DVD_W(DVD_W),
        .DVS_W(SUM_W),
        .Q_W  (F)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(dividend),
        .divisor (divisor),
        .quotient(quotient),
        .status  (div_stat)
    );

    assign dens_wide = 64'(mem_rd_reg) << (2 * n_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == MODE_WARP)
                    begin
                        state_next = S_RD_ISSUE;
                    end
                    else if (in_mode == MODE_DENSITY)
                    begin
                        state_next = S_DENS_RD;
                    end
                end
            end
            S_RD_ISSUE:   state_next = S_RD_CAPTURE;
            S_RD_CAPTURE: state_next = (k_reg == 2'd3) ? S_MUL : S_RD_ISSUE;
            S_MUL:        state_next = (tot == '0) ? S_FINISH : S_CMP;
            S_CMP:        state_next = (divisor == '0) ? S_FINISH : S_DIV;
            S_DIV:        state_next = div_stat.done ? S_FINISH : S_DIV;
            S_FINISH:
            begin
                if (!phase_reg)
                begin
                    state_next = S_MUL;
                end
                else if (NW'(lvl_reg) + 1'b1 < n_reg)
                begin
                    state_next = S_RD_ISSUE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DENS_RD:    state_next = S_DENS_CAP;
            S_DENS_CAP:   state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            levels_used_reg <= CFG_W'(6);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                levels_used_reg <= cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((accept && in_mode != MODE_WARP && in_mode != MODE_DENSITY)
                || state_reg == S_DENS_CAP
                || (state_reg == S_FINISH && state_next == S_IDLE))
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                x_reg     <= F'(in_u);
                y_reg     <= F'(in_v);
                n_reg     <= n_eff;
                lvl_reg   <= '0;
                k_reg     <= '0;
                r_reg     <= '0;
                c_reg     <= '0;
                // A finished result may still wait here for the receiver.
                if (accept)
                begin
                    out_x_reg <= '0;
                    out_y_reg <= '0;
                    out_d_reg <= '0;
                end
            end
            S_RD_ISSUE:
            begin
            end
            S_RD_CAPTURE:
            begin
                cell_reg[k_reg] <= mem_rd_reg;
                k_reg           <= k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    // Row sums: top pair against bottom pair.
                    sa_reg    <= SUM_W'(cell_reg[0]) + SUM_W'(cell_reg[1]);
                    sb_reg    <= SUM_W'(cell_reg[2]) + SUM_W'(mem_rd_reg);
                    phase_reg <= 1'b0;
                end
            end
            S_MUL:
            begin
                lhs_reg  <= DVD_W'(coord) * DVD_W'(tot);
                part_reg <= 1'b0;
                keep_reg <= 1'b1;
            end
            S_CMP:
            begin
                part_reg <= !lhs_lt;
                keep_reg <= (divisor == '0);
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    keep_reg <= 1'b0;
                end
            end
            S_FINISH:
            begin
                if (!phase_reg)
                begin
                    if (!keep_reg)
                    begin
                        y_reg <= quotient;
                    end
                    down_reg  <= part_reg;
                    phase_reg <= 1'b1;
                    // Column choice within the chosen row.
                    sa_reg <= part_reg ? SUM_W'(cell_reg[2]) : SUM_W'(cell_reg[0]);
                    sb_reg <= part_reg ? SUM_W'(cell_reg[3]) : SUM_W'(cell_reg[1]);
                end
                else
                begin
                    if (!keep_reg)
                    begin
                        x_reg <= quotient;
                    end
                    k_reg <= '0;
                    if (NW'(lvl_reg) + 1'b1 < n_reg)
                    begin
                        r_reg   <= (r_reg + ML'(down_reg)) << 1;
                        c_reg   <= (c_reg + ML'(part_reg)) << 1;
                        lvl_reg <= lvl_reg + 1'b1;
                    end
                    else
                    begin
                        out_x_reg <= COORD_W'((({c_reg + ML'(part_reg), F'(0)})
                                     + PW'(keep_reg ? x_reg : quotient)) >> n_reg);
                        out_y_reg <= COORD_W'((({r_reg + ML'(down_reg), F'(0)})
                                     + PW'(y_reg)) >> n_reg);
                    end
                end
            end
            S_DENS_RD:
            begin
            end
            S_DENS_CAP:
            begin
                out_d_reg <= (dens_wide[63:DENSITY_W] != '0) ? {DENSITY_W{1'b1}}
                             : dens_wide[DENSITY_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_d_reg, out_y_reg, out_x_reg});

    `HSW_ASSERT_IMPL(a_ready_empty, s_axis_tready, !m_axis_tvalid)
    `HSW_ASSERT_IMPL(a_div_in_state, div_stat.busy, state_reg == S_DIV || state_reg == S_CMP)
    `HSW_ASSERT_NEXT(a_warp_starts, accept && in_mode == MODE_WARP, state_reg == S_RD_ISSUE)

endmodule

// File: src/hsw_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on hsw_pkg; the quotient must fit in Q_W bits.
module hsw_div
    import hsw_pkg::*;
#(
    parameter int DVD_W = 50,
    parameter int DVS_W = 33,
    parameter int Q_W   = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [Q_W-1:0]   quotient,
    output div_status_t      status
);

    localparam int CW = $clog2(Q_W + 1);

    logic [DVD_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] ds_reg, ds_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ge;

    assign ge = (rem_reg >= ds_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        ds_next   = ds_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            ds_next   = DVD_W'(divisor) << (Q_W - 1);
            q_next    = '0;
            cnt_next  = CW'(Q_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - ds_reg;
            end
            q_next   = {q_reg[Q_W-2:0], ge};
            ds_next  = ds_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        ds_reg  <= ds_next;
        q_reg   <= q_next;
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for hierarchical_sample_warp: stream stimulus, scoreboard, checks.
// Depends on hsw_pkg and the hierarchical_sample_warp RTL.

module testbench;
    import hsw_pkg::*;

    // Mode 3 has no meaning for the block; it must still answer with an all-zero word.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int                NUM_LEVELS  = 6;
    localparam int                STORE_SIZE  = 5460;
    localparam longint unsigned   DENS_MAX    = (64'd1 << DENSITY_W) - 1;
    localparam longint unsigned   COORD_MASK  = 64'hFFFF;

    // Keeps a private copy of the weight pyramid and levels_used, predicts the
    // answer for every accepted word and checks the returned words in order.
    class warp_scoreboard;
        logic [WEIGHT_W-1:0]  pyramid[STORE_SIZE];
        logic [CFG_W-1:0]     levels_reg;
        logic [M_TDATA_W-1:0] answer_q[$];
        int                   errors;

        function new();
            levels_reg = 3'd6;
            errors     = 0;
        endfunction

        function longint unsigned level_base(int lvl);
            return ((64'd1 << (2 * lvl + 2)) - 4) / 3;
        endfunction

        function longint unsigned weight_at(int lvl, longint unsigned r,
                                            longint unsigned c);
            longint unsigned side;
            side = 64'd1 << (lvl + 1);
            if (lvl >= NUM_LEVELS || r >= side || c >= side)
                return 0;
            return pyramid[level_base(lvl) + r * side + c];
        endfunction

        // Returns 1 when the second part is taken; rescales crd into the chosen part.
        function bit split(inout longint unsigned crd, input longint unsigned a,
                           input longint unsigned b);
            longint unsigned prod;
            longint unsigned thresh;
            if (a + b == 0)
                return 1'b0;
            prod   = crd * (a + b);
            thresh = a << COORD_W;
            if (prod < thresh)
            begin
                if (a != 0)
                    crd = (prod / a) & COORD_MASK;
                return 1'b0;
            end
            if (b != 0)
                crd = ((prod - thresh) / b) & COORD_MASK;
            return 1'b1;
        endfunction

        function void note_word(logic [MODE_W-1:0] mode, logic [S_TDATA_W-1:0] data);
            int                   n;
            int                   lvl;
            longint unsigned      row;
            longint unsigned      col;
            longint unsigned      x;
            longint unsigned      y;
            longint unsigned      r;
            longint unsigned      c;
            longint unsigned      tl, tr, bl, br, d, wcell;
            bit                   down, right;
            logic [M_TDATA_W-1:0] ans;

            lvl = data[LEVEL_LSB +: LEVEL_W];
            row = data[ROW_LSB +: ROWCOL_W];
            col = data[COL_LSB +: ROWCOL_W];
            x   = data[U_LSB +: COORD_W];
            y   = data[V_LSB +: COORD_W];
            n   = (levels_reg < 1) ? 1 : (levels_reg > NUM_LEVELS) ? NUM_LEVELS : levels_reg;
            ans = '0;
            r   = 0;
            c   = 0;

            if (mode == MODE_WRITE)
            begin
                if (lvl < NUM_LEVELS && row < (64'd1 << (lvl + 1)) &&
                    col < (64'd1 << (lvl + 1)))
                    pyramid[level_base(lvl) + row * (64'd1 << (lvl + 1)) + col] =
                        data[WEIGHT_LSB +: WEIGHT_W];
            end
            else if (mode == MODE_WARP)
            begin
                for (int i = 0; i < n; i++)
                begin
                    tl    = weight_at(i, r, c);
                    tr    = weight_at(i, r, c + 1);
                    bl    = weight_at(i, r + 1, c);
                    br    = weight_at(i, r + 1, c + 1);
                    down  = split(y, tl + tr, bl + br);
                    right = down ? split(x, bl, br) : split(x, tl, tr);
                    r     = r + down;
                    c     = c + right;
                    if (i + 1 < n)
                    begin
                        r = r << 1;
                        c = c << 1;
                    end
                end
                ans[0 +: COORD_W]       = COORD_W'(((c << COORD_W) + x) >> n);
                ans[COORD_W +: COORD_W] = COORD_W'(((r << COORD_W) + y) >> n);
            end
            else if (mode == MODE_DENSITY)
            begin
                wcell = weight_at(n - 1, (y << n) >> COORD_W, (x << n) >> COORD_W);
                d     = wcell << (2 * n);
                if (d > DENS_MAX)
                    d = DENS_MAX;
                ans[2 * COORD_W +: DENSITY_W] = DENSITY_W'(d);
            end
            answer_q.push_back(ans);
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] want;
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = answer_q.pop_front();
            if (got[0 +: COORD_W] !== want[0 +: COORD_W])
            begin
                $display("%0t: x_out expected %h actual %h", $time,
                         want[0 +: COORD_W], got[0 +: COORD_W]);
                errors++;
            end
            if (got[COORD_W +: COORD_W] !== want[COORD_W +: COORD_W])
            begin
                $display("%0t: y_out expected %h actual %h", $time,
                         want[COORD_W +: COORD_W], got[COORD_W +: COORD_W]);
                errors++;
            end
            if (got[2 * COORD_W +: DENSITY_W] !== want[2 * COORD_W +: DENSITY_W])
            begin
                $display("%0t: density expected %h actual %h", $time,
                         want[2 * COORD_W +: DENSITY_W], got[2 * COORD_W +: DENSITY_W]);
                errors++;
            end
            if (got[M_TDATA_W-1:M_USED_W] !== '0)
            begin
                $display("%0t: pad bits expected 0 actual %h", $time,
                         got[M_TDATA_W-1:M_USED_W]);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;    // level, row, col, weight, u, v, zero pad
    logic [MODE_W-1:0]    s_axis_tuser;    // mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;    // x_out, y_out, density, zero pad

    warp_scoreboard sb;
    int             burst_left;

    hierarchical_sample_warp DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [S_TDATA_W-1:0] pack_word(int lvl, int row, int col,
                                                        logic [31:0] w,
                                                        logic [15:0] u, logic [15:0] v);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[LEVEL_LSB +: LEVEL_W]   = LEVEL_W'(lvl);
        word[ROW_LSB +: ROWCOL_W]    = ROWCOL_W'(row);
        word[COL_LSB +: ROWCOL_W]    = ROWCOL_W'(col);
        word[WEIGHT_LSB +: WEIGHT_W] = w;
        word[U_LSB +: COORD_W]       = u;
        word[V_LSB +: COORD_W]       = v;
        return word;
    endfunction

    // Coordinates lean on the edges of the unit square now and then.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    // Weights: zeros produce zero-denominator splits, large values stress the products.
    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 16);
            default: return $urandom();
        endcase
    endfunction

    // Drives one word at the falling edge and holds it until it is taken. The sender
    // works in bursts; between some bursts tvalid drops for a random number of cycles.
    task automatic send_word(logic [MODE_W-1:0] mode, logic [S_TDATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(mode, data);
        @(negedge clk);
    endtask

    // Lets every expected word come back, then lets the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.answer_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Called only while the block is idle.
    task automatic set_levels(logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.levels_reg = value;
        @(negedge clk);
    endtask

    task automatic send_random_word();
        int lvl;
        int side;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // Mostly out of range: level above the top or cell outside the side.
                send_word(MODE_WRITE, pack_word($urandom_range(0, 7), $urandom_range(0, 63),
                          $urandom_range(0, 63), $urandom(), 16'($urandom()),
                          16'($urandom())));
            end
            else
            begin
                lvl  = $urandom_range(0, NUM_LEVELS - 1);
                side = 1 << (lvl + 1);
                send_word(MODE_WRITE, pack_word(lvl, $urandom_range(0, side - 1),
                          $urandom_range(0, side - 1), rand_weight(), 16'($urandom()),
                          16'($urandom())));
            end
        end
        else if (pick < 75)
            send_word(MODE_WARP, pack_word($urandom_range(0, 7), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom(), rand_coord(), rand_coord()));
        else if (pick < 96)
            send_word(MODE_DENSITY, pack_word($urandom_range(0, 7), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom(), rand_coord(), rand_coord()));
        else
            send_word(MODE_UNUSED, pack_word($urandom_range(0, 7), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom(), 16'($urandom()),
                      16'($urandom())));
    endtask

    // Receiver: checks every word taken at a rising edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata);
        end
    end

    // Receiver stall pattern: stretches of always-ready, light and heavy stalling,
    // plus one long hold-off while the sender keeps offering words.
    initial
    begin
        int cycle_count;
        int style;
        int stretch;
        m_axis_tready = 1'b0;
        cycle_count   = 0;
        style         = 0;
        stretch       = 0;
        forever
        begin
            @(negedge clk);
            cycle_count++;
            if (stretch == 0)
            begin
                style   = $urandom_range(0, 2);
                stretch = $urandom_range(20, 400);
            end
            stretch--;
            if (cycle_count >= 3000 && cycle_count < 3600)
                m_axis_tready <= 1'b0;
            else if (style == 0)
                m_axis_tready <= 1'b1;
            else if (style == 1)
                m_axis_tready <= ($urandom_range(0, 1) == 1);
            else
                m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence.
    initial
    begin
        logic [CFG_W-1:0] phase_levels[8];
        int               lvl;
        int               side;

        sb            = new();
        burst_left    = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = MODE_WRITE;
        s_axis_tdata  = '0;
        phase_levels  = '{3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd4, 3'd5, 3'd6};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The weight memory is not cleared by reset, so every entry of the pyramid is
        // written before any warp or density query can read it.
        for (lvl = 0; lvl < NUM_LEVELS; lvl++)
        begin
            side = 1 << (lvl + 1);
            for (int r = 0; r < side; r++)
                for (int c = 0; c < side; c++)
                    send_word(MODE_WRITE, pack_word(lvl, r, c, rand_weight(),
                              16'($urandom()), 16'($urandom())));
        end

        // Directed part at the reset value of levels_used.
        // Writes that must be dropped: level above the top, row and col past the side.
        send_word(MODE_WRITE, pack_word(6, 0, 0, 32'hDEAD_BEEF, 16'hFFFF, 16'hFFFF));
        send_word(MODE_WRITE, pack_word(7, 63, 63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_word(MODE_WRITE, pack_word(0, 2, 0, 32'h1234_5678, 16'h0, 16'h0));
        send_word(MODE_WRITE, pack_word(2, 0, 63, 32'h1234_5678, 16'h0, 16'h0));
        // Warps at the corners and the middle, densities at the corners.
        send_word(MODE_WARP, pack_word(0, 0, 0, 32'd0, 16'h0000, 16'h0000));
        send_word(MODE_WARP, pack_word(0, 0, 0, 32'd0, 16'hFFFF, 16'hFFFF));
        send_word(MODE_WARP, pack_word(0, 0, 0, 32'd0, 16'h8000, 16'h8000));
        send_word(MODE_DENSITY, pack_word(0, 0, 0, 32'd0, 16'h0000, 16'h0000));
        send_word(MODE_DENSITY, pack_word(0, 0, 0, 32'd0, 16'hFFFF, 16'hFFFF));
        send_word(MODE_UNUSED, pack_word(7, 63, 63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        // A coarse block of all zeros: both splits see a zero denominator.
        for (int k = 0; k < 4; k++)
            send_word(MODE_WRITE, pack_word(0, k / 2, k % 2, 32'd0, 16'h0, 16'h0));
        send_word(MODE_WARP, pack_word(0, 0, 0, 32'd0, 16'h7FFF, 16'hC000));
        // One zero cell beside a full one: the split lands exactly on the boundary.
        send_word(MODE_WRITE, pack_word(0, 0, 0, 32'd1, 16'h0, 16'h0));
        send_word(MODE_WRITE, pack_word(0, 1, 0, 32'd1, 16'h0, 16'h0));
        send_word(MODE_WARP, pack_word(0, 0, 0, 32'd0, 16'h0000, 16'h8000));
        // Largest weight in the finest cell under the far corner.
        send_word(MODE_WRITE, pack_word(5, 63, 63, 32'hFFFF_FFFF, 16'h0, 16'h0));
        send_word(MODE_DENSITY, pack_word(0, 0, 0, 32'd0, 16'hFFFF, 16'hFFFF));
        send_word(MODE_WRITE, pack_word(0, 0, 1, rand_weight(), 16'h0, 16'h0));
        send_word(MODE_WRITE, pack_word(0, 1, 1, rand_weight(), 16'h0, 16'h0));

        // Random part at the reset setting, then through every other setting,
        // the out-of-range values 0 and 7 among them. Each drain is also a pause
        // of the sender until every answer has come back.
        for (int k = 0; k < 150; k++)
            send_random_word();
        foreach (phase_levels[p])
        begin
            drain();
            set_levels(phase_levels[p]);
            for (int k = 0; k < 130; k++)
                send_random_word();
        end

        drain();
        repeat (20) @(negedge clk);
        if (sb.answer_q.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, sb.answer_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
